// ===== hw/rtl/lsti_pkg.sv =====
// ----------------------------------------------------------------------------
// lsti_pkg
// Shared types, constants and the quarter-wave sine builder for the L-system
// turtle interpreter.
// ----------------------------------------------------------------------------
package lsti_pkg;

  // Sizes
  localparam int unsigned STACK_DEPTH = 128;
  localparam int unsigned SINE_BITS   = 10;
  localparam int unsigned QUARTER     = 1 << (SINE_BITS - 2);
  localparam int unsigned QTAB_AW     = SINE_BITS - 1;
  localparam int unsigned LEVEL_W     = $clog2(STACK_DEPTH + 1);
  localparam int unsigned STACK_AW    = $clog2(STACK_DEPTH);
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  // Fixed-point constants
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [15:0] NUDGE_PLUS  = 16'd364;  // +2 degrees
  localparam logic [15:0] NUDGE_MINUS = 16'd273;  // -1.5 degrees

  // Configuration register indexes
  localparam logic [2:0] CFG_SEG_LENGTH    = 3'd0;
  localparam logic [2:0] CFG_TURN_STEP     = 3'd1;
  localparam logic [2:0] CFG_START_HEADING = 3'd2;
  localparam logic [2:0] CFG_ORIGIN_X      = 3'd3;
  localparam logic [2:0] CFG_ORIGIN_Y      = 3'd4;

  // Configuration reset values
  localparam logic [7:0]  SEG_LENGTH_RST    = 8'd8;
  localparam logic [15:0] TURN_STEP_RST     = 16'd4551;
  localparam logic [15:0] START_HEADING_RST = 16'd49152;
  localparam logic [9:0]  ORIGIN_X_RST      = 10'd32;
  localparam logic [9:0]  ORIGIN_Y_RST      = 10'd64;

  // Symbol codes (ASCII)
  localparam logic [7:0] SYM_DRAW      = 8'h46;  // F
  localparam logic [7:0] SYM_MOVE      = 8'h66;  // f
  localparam logic [7:0] SYM_GO        = 8'h47;  // G
  localparam logic [7:0] SYM_PLUS      = 8'h2B;  // +
  localparam logic [7:0] SYM_MINUS     = 8'h2D;  // -
  localparam logic [7:0] SYM_MIRROR    = 8'h26;  // &
  localparam logic [7:0] SYM_NUDGE_UP  = 8'h78;  // x
  localparam logic [7:0] SYM_NUDGE_DN  = 8'h79;  // y
  localparam logic [7:0] SYM_PUSH      = 8'h5B;  // [
  localparam logic [7:0] SYM_POP       = 8'h5D;  // ]
  localparam logic [7:0] SYM_BUD       = 8'h42;  // B
  localparam logic [7:0] SYM_END       = 8'h00;  // end of string

  // Stack fault codes
  localparam logic [1:0] FAULT_NONE = 2'd0;
  localparam logic [1:0] FAULT_PUSH = 2'd1;
  localparam logic [1:0] FAULT_POP  = 2'd2;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_DRAW,
    OP_MOVE,
    OP_TURN_L,
    OP_TURN_R,
    OP_MIRROR,
    OP_NUDGE_UP,
    OP_NUDGE_DN,
    OP_PUSH,
    OP_POP,
    OP_BUD
  } lsti_op_e;

  typedef enum logic {
    ST_LOOK,
    ST_EXEC
  } lsti_state_e;

  typedef struct packed {
    logic [7:0] symbol;
    logic [7:0] next_symbol;
    logic       first_symbol;
  } lsti_in_t;

  typedef struct packed {
    logic               line_valid;
    logic               bud_valid;
    logic signed [15:0] from_x;
    logic signed [15:0] from_y;
    logic signed [15:0] to_x;
    logic signed [15:0] to_y;
    logic [1:0]         stack_fault;
  } lsti_out_t;

  // Classified symbol handed from front to back
  typedef struct packed {
    lsti_op_e op;
    logic     bud_end;  // next symbol is ] or end of string; the bud flag of F
    logic     first;
  } lsti_cmd_t;

  typedef struct packed {
    logic [7:0]  seg_length;
    logic [15:0] turn_step;
    logic [15:0] start_heading;
    logic [9:0]  origin_x;
    logic [9:0]  origin_y;
  } lsti_cfg_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [15:0]        heading;
  } lsti_turtle_t;

  // sin(pi/2 * k / QUARTER) in Q1.15 by a Taylor series; elaboration only.
  // Terms up to x^17, each divided by (2n)(2n+1) of its order.
  function automatic logic [14:0] quarter_sine(input int unsigned k);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic [63:0]        r;
    logic signed [63:0] sum;
    x    = (HALF_PI_Q30 * 64'(k)) / QUARTER;
    x2   = (x * x) >> 30;
    term = x;
    sum  = $signed(x);
    term = ((term * x2) >> 30) / 64'd6;
    sum  = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd20;
    sum  = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd42;
    sum  = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd72;
    sum  = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd110;
    sum  = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd156;
    sum  = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd210;
    sum  = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd272;
    sum  = sum + $signed(term);
    if (sum < 0) begin
      sum = '0;
    end
    r = ($unsigned(sum) + 64'd16384) >> 15;
    if (r > 64'd32767) begin
      r = 64'd32767;
    end
    return r[14:0];
  endfunction

endpackage

// ===== hw/rtl/lsti_front.sv =====
// ----------------------------------------------------------------------------
// lsti_front
// Accepts symbols, decodes them into turtle commands and buffers them in a
// short queue toward the execution back end.
// ----------------------------------------------------------------------------
module lsti_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  lsti_pkg::lsti_in_t in_data_i,
  output logic               cmd_valid_o,
  input  logic               cmd_ready_i,
  output lsti_pkg::lsti_cmd_t cmd_o
);
  import lsti_pkg::*;

  lsti_cmd_t           dec_cmd;
  lsti_cmd_t           q_mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QUEUE_AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QUEUE_CW-1:0] count_q, count_d;
  logic                push, pop;

  // Symbol decode
  always_comb begin
    dec_cmd.first   = in_data_i.first_symbol;
    dec_cmd.bud_end = (in_data_i.next_symbol == SYM_POP) ||
                      (in_data_i.next_symbol == SYM_END);
    case (in_data_i.symbol)
      SYM_DRAW:     dec_cmd.op = OP_DRAW;
      SYM_MOVE:     dec_cmd.op = OP_MOVE;
      SYM_GO:       dec_cmd.op = OP_MOVE;
      SYM_PLUS:     dec_cmd.op = OP_TURN_L;
      SYM_MINUS:    dec_cmd.op = OP_TURN_R;
      SYM_MIRROR:   dec_cmd.op = OP_MIRROR;
      SYM_NUDGE_UP: dec_cmd.op = OP_NUDGE_UP;
      SYM_NUDGE_DN: dec_cmd.op = OP_NUDGE_DN;
      SYM_PUSH:     dec_cmd.op = OP_PUSH;
      SYM_POP:      dec_cmd.op = OP_POP;
      SYM_BUD:      dec_cmd.op = OP_BUD;
      default:      dec_cmd.op = OP_NONE;
    endcase
  end

  // Queue control
  assign in_ready_o  = (count_q != QUEUE_CW'(QUEUE_DEPTH));
  assign cmd_valid_o = (count_q != '0);
  assign cmd_o       = q_mem[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = cmd_valid_o && cmd_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= dec_cmd;
    end
  end

endmodule

// ===== hw/rtl/lsti_back.sv =====
// ----------------------------------------------------------------------------
// lsti_back
// Executes turtle commands: restart, sine/cosine lookup, moves, turns and the
// push/pop stack, and holds the result register.
// ----------------------------------------------------------------------------
module lsti_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lsti_pkg::lsti_cfg_t  cfg_i,
  input  logic                 cmd_valid_i,
  output logic                 cmd_ready_o,
  input  lsti_pkg::lsti_cmd_t  cmd_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output lsti_pkg::lsti_out_t  out_o
);
  import lsti_pkg::*;

  // Quarter-wave sine table, built at elaboration
  logic [14:0] qtab [QUARTER + 1];

  for (genvar k = 0; k <= QUARTER; k++) begin : g_qtab
    localparam logic [14:0] QV = quarter_sine(k);
    assign qtab[k] = QV;
  end

  // Position step: (pos*32768 + len*trig) / 32768, truncated toward zero
  function automatic logic signed [15:0] advance(input logic signed [15:0] pos,
                                                 input logic signed [15:0] trig,
                                                 input logic [7:0]         len);
    logic signed [24:0] prod;
    logic signed [31:0] sum;
    logic signed [31:0] quo;
    prod = $signed({1'b0, len}) * trig;
    sum  = $signed({pos[15], pos, 15'd0}) + 32'(prod);
    quo  = sum >>> 15;
    if (sum[31] && (sum[14:0] != '0)) begin
      quo = quo + 32'sd1;
    end
    return quo[15:0];
  endfunction

  lsti_state_e         state_q, state_d;
  lsti_cmd_t           cmd_q;
  logic signed [15:0]  x_q, x_d;
  logic signed [15:0]  y_q, y_d;
  logic [15:0]         heading_q, heading_d;
  logic [LEVEL_W-1:0]  level_q, level_d;
  logic signed [15:0]  sin_q, cos_q;
  lsti_turtle_t        stack_mem [STACK_DEPTH];
  lsti_turtle_t        stk_rd_q;
  logic                out_valid_q;
  lsti_out_t           out_q, out_d;

  logic                take;
  logic                fire;
  logic                out_free;
  logic                push_ok;

  // Lookup side signals
  logic [15:0]          heading_eff;
  logic [LEVEL_W-1:0]   level_eff;
  logic [LEVEL_W-1:0]   rd_lvl;
  logic [SINE_BITS-1:0] idx_s, idx_c;
  logic [QTAB_AW-1:0]   k_s, k_c;
  logic signed [15:0]   sin_d, cos_d;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_LOOK: begin
        if (cmd_valid_i) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        if (out_free) state_d = ST_LOOK;
      end
      default: state_d = ST_LOOK;
    endcase
  end

  // State outputs
  always_comb begin
    cmd_ready_o = 1'b0;
    fire        = 1'b0;
    case (state_q)
      ST_LOOK: cmd_ready_o = 1'b1;
      ST_EXEC: fire        = out_free;
      default: begin
        cmd_ready_o = 1'b0;
        fire        = 1'b0;
      end
    endcase
  end

  assign out_free = !out_valid_q || out_ready_i;
  assign take     = cmd_ready_o && cmd_valid_i;
  assign push_ok  = (level_q != LEVEL_W'(STACK_DEPTH));

  // Lookup: restart view of the turtle, table and stack addresses
  always_comb begin
    heading_eff = cmd_i.first ? cfg_i.start_heading : heading_q;
    level_eff   = cmd_i.first ? '0 : level_q;
    rd_lvl      = level_eff - LEVEL_W'(1);
    idx_s       = heading_eff[15 -: SINE_BITS];
    idx_c       = idx_s + SINE_BITS'(QUARTER);
    k_s = idx_s[SINE_BITS-2] ? QTAB_AW'(QUARTER) - QTAB_AW'(idx_s[SINE_BITS-3:0])
                             : QTAB_AW'(idx_s[SINE_BITS-3:0]);
    k_c = idx_c[SINE_BITS-2] ? QTAB_AW'(QUARTER) - QTAB_AW'(idx_c[SINE_BITS-3:0])
                             : QTAB_AW'(idx_c[SINE_BITS-3:0]);
    sin_d = idx_s[SINE_BITS-1] ? -$signed({1'b0, qtab[k_s]}) : $signed({1'b0, qtab[k_s]});
    cos_d = idx_c[SINE_BITS-1] ? -$signed({1'b0, qtab[k_c]}) : $signed({1'b0, qtab[k_c]});
  end

  // Execute: turtle update and result
  always_comb begin
    x_d       = x_q;
    y_d       = y_q;
    heading_d = heading_q;
    level_d   = level_q;
    out_d.line_valid  = 1'b0;
    out_d.bud_valid   = 1'b0;
    out_d.stack_fault = FAULT_NONE;
    case (cmd_q.op)
      OP_DRAW, OP_MOVE: begin
        x_d = advance(x_q, cos_q, cfg_i.seg_length);
        y_d = advance(y_q, sin_q, cfg_i.seg_length);
        if (cmd_q.op == OP_DRAW) begin
          out_d.line_valid = 1'b1;
          out_d.bud_valid  = cmd_q.bud_end;
        end
      end
      OP_TURN_L:   heading_d = heading_q + cfg_i.turn_step;
      OP_TURN_R:   heading_d = heading_q - cfg_i.turn_step;
      OP_MIRROR:   heading_d = 16'd0 - heading_q;
      OP_NUDGE_UP: heading_d = heading_q + NUDGE_PLUS;
      OP_NUDGE_DN: heading_d = heading_q - NUDGE_MINUS;
      OP_PUSH: begin
        if (push_ok) begin
          level_d = level_q + 1'b1;
        end else begin
          out_d.stack_fault = FAULT_PUSH;
        end
      end
      OP_POP: begin
        out_d.bud_valid = 1'b1;
        if (level_q == '0) begin
          out_d.stack_fault = FAULT_POP;
        end else begin
          level_d   = level_q - 1'b1;
          x_d       = stk_rd_q.x;
          y_d       = stk_rd_q.y;
          heading_d = stk_rd_q.heading;
        end
      end
      OP_BUD:  out_d.bud_valid = 1'b1;
      default: level_d = level_q;
    endcase
    out_d.from_x = x_q;
    out_d.from_y = y_q;
    out_d.to_x   = x_d;
    out_d.to_y   = y_d;
  end

  // Control and turtle registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOOK;
      x_q         <= 16'($signed({1'b0, ORIGIN_X_RST}));
      y_q         <= 16'($signed({1'b0, ORIGIN_Y_RST}));
      heading_q   <= START_HEADING_RST;
      level_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (take && cmd_i.first) begin
        x_q       <= 16'($signed({1'b0, cfg_i.origin_x}));
        y_q       <= 16'($signed({1'b0, cfg_i.origin_y}));
        heading_q <= cfg_i.start_heading;
        level_q   <= '0;
      end else if (fire) begin
        x_q       <= x_d;
        y_q       <= y_d;
        heading_q <= heading_d;
        level_q   <= level_d;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers: command, trig values, result
  always_ff @(posedge clk_i) begin
    if (take) begin
      cmd_q <= cmd_i;
      sin_q <= sin_d;
      cos_q <= cos_d;
    end
    if (fire) begin
      out_q <= out_d;
    end
  end

  // Turtle stack memory: registered read on lookup, write on push
  always_ff @(posedge clk_i) begin
    if (take) begin
      stk_rd_q <= stack_mem[rd_lvl[STACK_AW-1:0]];
    end
    if (fire && (cmd_q.op == OP_PUSH) && push_ok) begin
      stack_mem[level_q[STACK_AW-1:0]] <= '{x: x_q, y: y_q, heading: heading_q};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

`ifndef ASSERT_OFF
  a_level_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    level_q <= LEVEL_W'(STACK_DEPTH))
    else $error("stack level beyond depth");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && (cmd_q.op == OP_PUSH) && push_ok) |=> (level_q == $past(level_q) + 1'b1))
    else $error("accepted push did not raise the stack level");

  a_level_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EXEC && cmd_q.op != OP_PUSH && cmd_q.op != OP_POP)
      |=> (level_q == $past(level_q)))
    else $error("stack level moved without push or pop");

  a_exec_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EXEC && !out_free) |=> (state_q == ST_EXEC && $stable(heading_q)))
    else $error("execute left while result register blocked");

  a_line_no_fault: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.line_valid) |-> (out_q.stack_fault == FAULT_NONE))
    else $error("segment reported together with a stack fault");
`endif

endmodule

// ===== hw/rtl/lsystem_turtle_interpreter.sv =====
// ----------------------------------------------------------------------------
// lsystem_turtle_interpreter
// L-system turtle: one symbol in, one segment/bud/fault result out.
// ----------------------------------------------------------------------------
//  Channel | Signals                               | Direction
//  --------+---------------------------------------+----------
//  in      | in_valid_i, in_ready_o, in_data_i     | symbol in
//  out     | out_valid_o, out_ready_i, out_data_o  | result out
//  cfg     | cfg_we_i, cfg_index_i, cfg_data_i     | register write
//
//  Each symbol passes two back-end states, LOOK (table and stack read) and
//  EXEC (execute), so the back end takes no new symbol until the last one
//  has executed, and EXEC holds while the result register is blocked.
//  An accepted symbol passes the queue, LOOK and EXEC into the result register.
//  A 2-entry command queue keeps accepting while a result waits to be taken.
//  Reset puts the turtle at the reset origin and heading with an empty stack;
//  stack contents are undefined until pushed.
// ----------------------------------------------------------------------------
module lsystem_turtle_interpreter (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  lsti_pkg::lsti_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output lsti_pkg::lsti_out_t out_data_o,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_index_i,
  input  logic [15:0]         cfg_data_i
);
  import lsti_pkg::*;

  lsti_cfg_t cfg_q;
  lsti_cmd_t cmd;
  logic      cmd_valid;
  logic      cmd_ready;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.seg_length    <= SEG_LENGTH_RST;
      cfg_q.turn_step     <= TURN_STEP_RST;
      cfg_q.start_heading <= START_HEADING_RST;
      cfg_q.origin_x      <= ORIGIN_X_RST;
      cfg_q.origin_y      <= ORIGIN_Y_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_SEG_LENGTH:    cfg_q.seg_length    <= cfg_data_i[7:0];
        CFG_TURN_STEP:     cfg_q.turn_step     <= cfg_data_i;
        CFG_START_HEADING: cfg_q.start_heading <= cfg_data_i;
        CFG_ORIGIN_X:      cfg_q.origin_x      <= cfg_data_i[9:0];
        CFG_ORIGIN_Y:      cfg_q.origin_y      <= cfg_data_i[9:0];
        default:           cfg_q               <= cfg_q;
      endcase
    end
  end

  // Decode and queue
  lsti_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  // Turtle execution
  lsti_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_data_o)
  );

endmodule

// ===== dv/lsti_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lsti_checker
// Watches the symbol, result and register ports of the turtle interpreter,
// keeps its own turtle, pose stack and register copy, and compares every
// result transaction against the oldest predicted result.
// ----------------------------------------------------------------------------
module lsti_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  lsti_pkg::lsti_in_t  in_data_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  lsti_pkg::lsti_out_t out_data_i,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_index_i,
  input  logic [15:0]         cfg_data_i,
  output int                  mismatch_cnt_o,
  output int                  pending_o
);
  import lsti_pkg::*;

  localparam int TAB_N = 1 << SINE_BITS;

  int           sine_q15 [TAB_N];
  lsti_cfg_t    regs;
  lsti_turtle_t pose;
  lsti_turtle_t pose_stack [STACK_DEPTH];
  int           stack_used;
  lsti_out_t    results_q [$];
  int           result_idx;

  // sin(pi/2 * k / QUARTER) in Q1.15, integer series, rounded and saturated
  function automatic int quarter_wave(int unsigned k);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned r;
    longint          sum;
    x    = HALF_PI_Q30 * longint'(k) / longint'(QUARTER);
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    for (int n = 1; n <= 8; n++) begin
      term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    r = (64'(sum) + 64'd16384) >> 15;
    if (r > 64'd32767) begin
      r = 64'd32767;
    end
    return int'(r);
  endfunction

  // full-turn table from the quarter wave
  initial begin
    for (int i = 0; i < TAB_N; i++) begin
      int unsigned quad;
      int unsigned rem;
      int          v;
      quad = (i >> (SINE_BITS - 2)) & 3;
      rem  = i & (QUARTER - 1);
      v    = quarter_wave((quad & 1) ? QUARTER - rem : rem);
      sine_q15[i] = (quad >= 2) ? -v : v;
    end
  end

  // new coordinate: (pos*32768 + len*trig) / 32768, truncated toward zero
  function automatic logic signed [15:0] step_coord(logic signed [15:0] pos, int trig);
    longint acc;
    acc = longint'(pos) * 32768 + longint'(regs.seg_length) * trig;
    return 16'(acc / 32768);
  endfunction

  // one symbol through the turtle; updates pose and stack
  function automatic lsti_out_t predict_turtle(lsti_in_t item);
    lsti_out_t         res;
    logic [SINE_BITS-1:0] idx;
    logic [SINE_BITS-1:0] cos_idx;
    res = '0;
    if (item.first_symbol) begin
      pose.x       = {6'b0, regs.origin_x};
      pose.y       = {6'b0, regs.origin_y};
      pose.heading = regs.start_heading;
      stack_used   = 0;
    end
    res.from_x = pose.x;
    res.from_y = pose.y;
    case (item.symbol)
      SYM_DRAW, SYM_MOVE, SYM_GO: begin
        idx     = pose.heading[15 -: SINE_BITS];
        cos_idx = idx + SINE_BITS'(QUARTER);
        pose.x  = step_coord(pose.x, sine_q15[cos_idx]);
        pose.y  = step_coord(pose.y, sine_q15[idx]);
        if (item.symbol == SYM_DRAW) begin
          res.line_valid = 1'b1;
          res.bud_valid  = (item.next_symbol == SYM_POP) || (item.next_symbol == SYM_END);
        end
      end
      SYM_PLUS:     pose.heading = pose.heading + regs.turn_step;
      SYM_MINUS:    pose.heading = pose.heading - regs.turn_step;
      SYM_MIRROR:   pose.heading = 16'd0 - pose.heading;
      SYM_NUDGE_UP: pose.heading = pose.heading + NUDGE_PLUS;
      SYM_NUDGE_DN: pose.heading = pose.heading - NUDGE_MINUS;
      SYM_PUSH: begin
        if (stack_used >= STACK_DEPTH) begin
          res.stack_fault = FAULT_PUSH;
        end else begin
          pose_stack[stack_used] = pose;
          stack_used++;
        end
      end
      SYM_POP: begin
        // bud sits at the pose before the pop, even when the pop is refused
        res.bud_valid = 1'b1;
        if (stack_used == 0) begin
          res.stack_fault = FAULT_POP;
        end else begin
          stack_used--;
          pose = pose_stack[stack_used];
        end
      end
      SYM_BUD: res.bud_valid = 1'b1;
      default: ;
    endcase
    res.to_x = pose.x;
    res.to_y = pose.y;
    return res;
  endfunction

  // register copy, prediction and comparison
  always @(posedge clk_i or negedge rst_ni) begin
    lsti_out_t exp_res;
    if (!rst_ni) begin
      regs.seg_length    = SEG_LENGTH_RST;
      regs.turn_step     = TURN_STEP_RST;
      regs.start_heading = START_HEADING_RST;
      regs.origin_x      = ORIGIN_X_RST;
      regs.origin_y      = ORIGIN_Y_RST;
      pose.x             = {6'b0, ORIGIN_X_RST};
      pose.y             = {6'b0, ORIGIN_Y_RST};
      pose.heading       = START_HEADING_RST;
      stack_used         = 0;
      result_idx         = 0;
      results_q.delete();
      mismatch_cnt_o     = 0;
      pending_o          = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_SEG_LENGTH:    regs.seg_length    = cfg_data_i[7:0];
          CFG_TURN_STEP:     regs.turn_step     = cfg_data_i;
          CFG_START_HEADING: regs.start_heading = cfg_data_i;
          CFG_ORIGIN_X:      regs.origin_x      = cfg_data_i[9:0];
          CFG_ORIGIN_Y:      regs.origin_y      = cfg_data_i[9:0];
          default: ;
        endcase
      end
      // symbol transaction: queue its result first, so oldest-first holds
      if (in_valid_i && in_ready_i) begin
        results_q.push_back(predict_turtle(in_data_i));
      end
      // result transaction
      if (out_valid_i && out_ready_i) begin
        if (results_q.size() == 0) begin
          mismatch_cnt_o++;
          if (mismatch_cnt_o <= 10) begin
            $display("%0t ERROR: result %0d arrived with nothing pending", $realtime,
                     result_idx);
          end
        end else begin
          exp_res = results_q.pop_front();
          if (out_data_i.line_valid  !== exp_res.line_valid  ||
              out_data_i.bud_valid   !== exp_res.bud_valid   ||
              out_data_i.from_x      !== exp_res.from_x      ||
              out_data_i.from_y      !== exp_res.from_y      ||
              out_data_i.to_x        !== exp_res.to_x        ||
              out_data_i.to_y        !== exp_res.to_y        ||
              out_data_i.stack_fault !== exp_res.stack_fault) begin
            mismatch_cnt_o++;
            if (mismatch_cnt_o <= 10) begin
              $display("%0t ERROR: result %0d", $realtime, result_idx);
              $display("  exp line=%0b bud=%0b from=(%0d,%0d) to=(%0d,%0d) fault=%0d",
                       exp_res.line_valid, exp_res.bud_valid, exp_res.from_x,
                       exp_res.from_y, exp_res.to_x, exp_res.to_y, exp_res.stack_fault);
              $display("  got line=%0b bud=%0b from=(%0d,%0d) to=(%0d,%0d) fault=%0d",
                       out_data_i.line_valid, out_data_i.bud_valid, out_data_i.from_x,
                       out_data_i.from_y, out_data_i.to_x, out_data_i.to_y,
                       out_data_i.stack_fault);
            end
          end
        end
        result_idx++;
      end
      pending_o = results_q.size();
    end
  end

endmodule

// ===== dv/lsystem_turtle_interpreter_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lsystem_turtle_interpreter_tb
// Drives symbol strings into the turtle interpreter under several register
// settings, with random gaps and stalls on both channels, a long output
// hold-off and a full drain; the checker module judges every result.
// ----------------------------------------------------------------------------
module lsystem_turtle_interpreter_tb;
  import lsti_pkg::*;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid;
  logic        in_ready;
  lsti_in_t    in_data;
  logic        out_valid;
  logic        out_ready;
  lsti_out_t   out_data;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;
  int          mismatch_cnt;
  int          pending_cnt;

  bit idle_en;
  int hold_len;
  int items_sent;

  lsystem_turtle_interpreter u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  lsti_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .in_data_i     (in_data),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .out_data_i    (out_data),
    .cfg_we_i      (cfg_we),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .mismatch_cnt_o(mismatch_cnt),
    .pending_o     (pending_cnt)
  );

  // 8 ns clock
  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // run limit
  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

  // result side: random stalls, plus a long hold-off on request
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(negedge clk_i);
      if (!rst_ni) begin
        out_ready <= 1'b0;
      end else if (hold_len > 0) begin
        out_ready <= 1'b0;
        repeat (hold_len) @(negedge clk_i);
        hold_len = 0;
      end else if (idle_en && $urandom_range(0, 99) < 7) begin
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // one symbol transaction; called and returns at a falling edge
  task automatic send_item(input lsti_in_t item);
    if (idle_en && $urandom_range(0, 99) < 7) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk_i); while (!in_ready);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_one(input logic [7:0] sym, input logic [7:0] nxt, input logic first);
    lsti_in_t item;
    item.symbol       = sym;
    item.next_symbol  = nxt;
    item.first_symbol = first;
    send_item(item);
  endtask

  // a string with exact lookahead and a restart on its first symbol
  task automatic send_symbols(input logic [7:0] syms[$]);
    for (int i = 0; i < syms.size(); i++) begin
      send_one(syms[i], (i == syms.size() - 1) ? SYM_END : syms[i + 1], i == 0);
    end
  endtask

  function automatic logic [7:0] pick_symbol(int depth);
    int r;
    r = $urandom_range(0, 99);
    if (r < 22) return SYM_DRAW;
    if (r < 28) return SYM_MOVE;
    if (r < 32) return SYM_GO;
    if (r < 42) return SYM_PLUS;
    if (r < 52) return SYM_MINUS;
    if (r < 56) return SYM_MIRROR;
    if (r < 61) return SYM_NUDGE_UP;
    if (r < 66) return SYM_NUDGE_DN;
    if (r < 76) return SYM_PUSH;
    if (r < 86) begin
      // an unmatched close is kept now and then to hit the empty stack
      return (depth == 0 && $urandom_range(0, 3) != 0) ? SYM_DRAW : SYM_POP;
    end
    if (r < 91) return SYM_BUD;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_random_string(input int len);
    logic [7:0] syms[$];
    logic [7:0] sym;
    int         depth;
    depth = 0;
    for (int i = 0; i < len; i++) begin
      sym = pick_symbol(depth);
      if (sym == SYM_PUSH) depth++;
      if (sym == SYM_POP && depth > 0) depth--;
      syms.push_back(sym);
    end
    // half the time close what was opened
    if ($urandom_range(0, 1) == 1) begin
      repeat (depth) syms.push_back(SYM_POP);
    end
    send_symbols(syms);
  endtask

  // broken strings: wrong lookahead, stray restarts
  task automatic send_noise(input int len);
    for (int i = 0; i < len; i++) begin
      send_one(pick_symbol(0), 8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
    end
  endtask

  task automatic run_random(input int target);
    int start;
    start = items_sent;
    while (items_sent - start < target) begin
      if ($urandom_range(0, 9) < 8) begin
        send_random_string($urandom_range(1, 24));
      end else begin
        send_noise($urandom_range(1, 8));
      end
    end
  endtask

  // pushes past a full stack, then pops past an empty one
  task automatic send_deep_string();
    logic [7:0] syms[$];
    syms.push_back(SYM_DRAW);
    for (int i = 0; i < STACK_DEPTH + 2; i++) begin
      syms.push_back(SYM_PUSH);
      if (i % 32 == 0) begin
        syms.push_back(SYM_PLUS);
        syms.push_back(SYM_DRAW);
      end
    end
    for (int i = 0; i < STACK_DEPTH + 3; i++) begin
      if (i % 40 == 0) syms.push_back(SYM_DRAW);
      syms.push_back(SYM_POP);
    end
    send_symbols(syms);
  endtask

  // stop offering and wait for every pending result, then the pipe latency
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_cnt != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // write all five registers; upper data bits carry junk for narrow ones
  task automatic program_regs(input logic [7:0] seg, input logic [15:0] turn,
                              input logic [15:0] head, input logic [9:0] ox,
                              input logic [9:0] oy);
    logic [2:0]  idx [5];
    logic [15:0] val [5];
    idx = '{CFG_SEG_LENGTH, CFG_TURN_STEP, CFG_START_HEADING, CFG_ORIGIN_X, CFG_ORIGIN_Y};
    val = '{{8'($urandom), seg}, turn, head, {6'($urandom), ox}, {6'($urandom), oy}};
    for (int i = 0; i < 5; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      @(negedge clk_i);
    end
    cfg_we <= 1'b0;
  endtask

  // stimulus and verdict
  initial begin
    logic [7:0] run_syms[$];
    rst_ni     <= 1'b0;
    in_valid   <= 1'b0;
    in_data    <= '0;
    cfg_we     <= 1'b0;
    cfg_index  <= CFG_SEG_LENGTH;
    cfg_data   <= '0;
    idle_en    = 1'b1;
    hold_len   = 0;
    items_sent = 0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: reset turtle, every symbol, bud and stack corner cases
    send_one(SYM_DRAW, SYM_DRAW, 1'b0);
    send_one(SYM_PLUS, SYM_MINUS, 1'b0);
    send_one(SYM_MINUS, SYM_MIRROR, 1'b0);
    send_one(SYM_MIRROR, SYM_NUDGE_UP, 1'b0);
    send_one(SYM_NUDGE_UP, SYM_NUDGE_DN, 1'b0);
    send_one(SYM_NUDGE_DN, SYM_MOVE, 1'b0);
    send_one(SYM_MOVE, SYM_GO, 1'b0);
    send_one(SYM_GO, SYM_POP, 1'b0);
    send_one(SYM_POP, SYM_PUSH, 1'b0);       // pop of empty stack
    send_one(SYM_PUSH, SYM_DRAW, 1'b0);
    send_one(SYM_DRAW, SYM_POP, 1'b0);       // bud after F before close
    send_one(SYM_POP, SYM_BUD, 1'b0);
    send_one(SYM_BUD, SYM_DRAW, 1'b0);
    send_one(SYM_DRAW, SYM_END, 1'b0);       // bud after F at end of string
    send_one(8'hFF, 8'hFF, 1'b1);            // unknown symbol with restart
    send_one(SYM_END, SYM_END, 1'b0);
    send_one(SYM_PUSH, SYM_PLUS, 1'b1);      // restart drops the stack
    send_one(SYM_PLUS, SYM_POP, 1'b0);
    send_one(SYM_POP, SYM_POP, 1'b1);
    send_one(8'h80, 8'h7F, 1'b0);
    drain_results();

    // all registers at their maximum: position wrap and stack overflow
    program_regs(8'd255, 16'hFFFF, 16'hFFFF, 10'd1023, 10'd1023);
    repeat (160) run_syms.push_back(SYM_DRAW);
    send_symbols(run_syms);
    send_deep_string();
    run_random(150);
    drain_results();

    // all registers at zero
    program_regs(8'd0, 16'd0, 16'd0, 10'd0, 10'd0);
    run_random(100);
    drain_results();

    // random setting: long output hold-off, then a full pause
    program_regs(8'($urandom_range(0, 255)), 16'($urandom), 16'($urandom),
                 10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)));
    run_random(100);
    hold_len = 80;
    run_random(100);
    drain_results();
    run_random(100);
    send_deep_string();
    drain_results();

    // random setting with no idling on either side
    idle_en = 1'b0;
    program_regs(8'($urandom_range(0, 255)), 16'($urandom), 16'($urandom),
                 10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)));
    run_random(150);
    drain_results();
    idle_en = 1'b1;

    drain_results();
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== lsystem_turtle_interpreter.f =====
hw/rtl/lsti_pkg.sv
hw/rtl/lsti_front.sv
hw/rtl/lsti_back.sv
hw/rtl/lsystem_turtle_interpreter.sv
dv/lsti_checker.sv
dv/lsystem_turtle_interpreter_tb.sv
